// ===== src/ttrrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ttrrs_pkg
// shared types and constants of the round-robin thread table scheduler
// ----------------------------------------------------------------------------
package ttrrs_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int VALUE_W    = 64;
    localparam int WCOUNT_W   = 5;
    localparam int LIVE_W     = 5;
    localparam int WAITER_W   = SLOTS + WCOUNT_W;
    localparam logic [SLOT_W-1:0] RESERVED_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [LIVE_W-1:0] LIVE_MAX      = '1;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_FINISHED = 2'd1,
        ST_READY    = 2'd2,
        ST_BLOCKED  = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_EXIT     = 3'd1,
        CMD_BLOCK    = 3'd2,
        CMD_WAKEUP   = 3'd3,
        CMD_JOIN     = 3'd4,
        CMD_SCHEDULE = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NO_FREE  = 3'd1,
        STS_INVALID  = 3'd2,
        STS_BLOCKED  = 3'd3,
        STS_NONE_RDY = 3'd4,
        STS_ALL_DONE = 3'd5
    } t_status;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_EXEC = 1'b1
    } t_phase;

endpackage

// ===== src/ttrrs_ram.sv =====
// ----------------------------------------------------------------------------
// ttrrs_ram
// single-port write, single-port read ram with registered read data
// ----------------------------------------------------------------------------
module ttrrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/thread_table_round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// thread_table_round_robin_scheduler
// per-slot thread table with create, exit, block, wakeup, join and
// round-robin schedule commands
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  s_axis  | in  | command[2:0] target_id[6:3] exit_value[70:7]
//  m_axis  | out | status[2:0] thread_id[6:3] join_value[70:7] live_threads[75:71]
//
//  every command runs through the idle and exec phases: the accept cycle issues
//  the read of the return-value and waiter rams, the exec phase modifies and
//  writes back and loads the result register. one command is in flight at a time.
//  a new word is taken while the last result is being taken.
//  synchronous active-low reset, no clearing pass (waiter rows carry valid bits).
// ----------------------------------------------------------------------------
module thread_table_round_robin_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // command, target_id, exit_value, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // status, thread_id, join_value, live_threads, pad
);

    localparam int SW = ttrrs_pkg::SLOT_W;
    localparam int N  = ttrrs_pkg::SLOTS;

    ttrrs_pkg::t_phase r_phase, n_phase;
    ttrrs_pkg::t_slot_st r_slot_state [N];
    ttrrs_pkg::t_slot_st n_slot_state [N];
    logic [N-1:0]  r_wvalid, n_wvalid;
    logic [SW-1:0] r_cur, n_cur, r_scan, n_scan;
    logic [ttrrs_pkg::LIVE_W-1:0] r_live, n_live;

    ttrrs_pkg::t_cmd r_cmd;
    logic [3:0]  r_tgt;
    logic [63:0] r_val;

    logic        r_ovalid;
    logic [79:0] r_odata, n_odata;
    logic        load_out;

    logic        accept;
    logic [SW-1:0] raddr;
    logic [63:0] rv_rdata;
    logic [ttrrs_pkg::WAITER_W-1:0] w_rdata, w_wdata;
    logic        rv_we, w_we;
    logic [N-1:0]  w_mask;
    logic [ttrrs_pkg::WCOUNT_W-1:0] w_count;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign raddr  = (ttrrs_pkg::t_cmd'(s_axis_tdata[2:0]) == ttrrs_pkg::CMD_EXIT)
                    ? r_cur : s_axis_tdata[3 +: SW];

    ttrrs_ram #(.WIDTH(64), .DEPTH(N)) u_rv_ram (
        .i_clk(i_clk), .i_we(rv_we), .i_waddr(r_cur), .i_wdata(r_val),
        .i_raddr(raddr), .o_rdata(rv_rdata)
    );

    ttrrs_ram #(.WIDTH(ttrrs_pkg::WAITER_W), .DEPTH(N)) u_waiter_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_tgt[SW-1:0]), .i_wdata(w_wdata),
        .i_raddr(raddr), .o_rdata(w_rdata)
    );

    // rows never written since create or free read as zero
    assign w_mask  = r_wvalid[r_tgt[SW-1:0]] ? w_rdata[N-1:0] : '0;
    assign w_count = r_wvalid[r_tgt[SW-1:0]] ? w_rdata[N +: ttrrs_pkg::WCOUNT_W] : '0;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            ttrrs_pkg::PH_IDLE: if (accept) n_phase = ttrrs_pkg::PH_EXEC;
            ttrrs_pkg::PH_EXEC: n_phase = ttrrs_pkg::PH_IDLE;
            default:            n_phase = ttrrs_pkg::PH_IDLE;
        endcase
    end

    // phase outputs
    always_comb begin
        s_axis_tready = (r_phase == ttrrs_pkg::PH_IDLE) && (!r_ovalid || m_axis_tready);
        load_out      = (r_phase == ttrrs_pkg::PH_EXEC);
    end

    // execute
    always_comb begin
        logic [N-1:0] rdy, free_v, hi;
        logic         found;
        logic [SW-1:0] pick;
        logic         tgt_ok;
        logic         cur_live;
        ttrrs_pkg::t_slot_st tst;
        ttrrs_pkg::t_status sts;
        logic [3:0]   tid;
        logic [63:0]  jv;
        logic [ttrrs_pkg::WCOUNT_W-1:0] dec;

        for (int i = 0; i < N; i++) n_slot_state[i] = r_slot_state[i];
        n_wvalid = r_wvalid;
        n_cur    = r_cur;
        n_scan   = r_scan;
        n_live   = r_live;
        rv_we    = 1'b0;
        w_we     = 1'b0;
        w_wdata  = '0;
        sts      = ttrrs_pkg::STS_OK;
        tid      = 4'(r_cur);
        jv       = '0;
        found    = 1'b0;
        pick     = '0;
        dec      = '0;

        for (int i = 0; i < N; i++) begin
            rdy[i]    = (r_slot_state[i] == ttrrs_pkg::ST_READY) && (SW'(i) != ttrrs_pkg::RESERVED_SLOT);
            free_v[i] = (r_slot_state[i] == ttrrs_pkg::ST_FREE) && (i != 0)
                        && (SW'(i) != ttrrs_pkg::RESERVED_SLOT);
            hi[i]     = SW'(i) >= r_scan;
        end
        tgt_ok   = (32'(r_tgt) < N);
        tst      = tgt_ok ? r_slot_state[r_tgt[SW-1:0]] : ttrrs_pkg::ST_FREE;
        cur_live = (r_slot_state[r_cur] == ttrrs_pkg::ST_READY)
                   || (r_slot_state[r_cur] == ttrrs_pkg::ST_BLOCKED);

        if (r_phase == ttrrs_pkg::PH_EXEC) begin
            unique case (r_cmd)
                ttrrs_pkg::CMD_CREATE: begin
                    for (int i = N - 1; i >= 0; i--) begin
                        if (free_v[i]) begin
                            found = 1'b1;
                            pick  = SW'(i);
                        end
                    end
                    if (found) begin
                        n_slot_state[pick] = ttrrs_pkg::ST_READY;
                        n_wvalid[pick]     = 1'b0;
                        if (r_live != ttrrs_pkg::LIVE_MAX) n_live = r_live + 1'b1;
                        tid = 4'(pick);
                    end else begin
                        sts = ttrrs_pkg::STS_NO_FREE;
                        tid = '0;
                    end
                end
                ttrrs_pkg::CMD_EXIT: begin
                    if (!cur_live) begin
                        sts = ttrrs_pkg::STS_INVALID;
                    end else begin
                        rv_we = 1'b1;
                        if (r_live != '0) n_live = r_live - 1'b1;
                        // waiter row was read at the current slot
                        for (int i = 0; i < N; i++) begin
                            if (r_wvalid[r_cur] && w_rdata[i] && (SW'(i) != r_cur)
                                && ((r_slot_state[i] == ttrrs_pkg::ST_READY)
                                 || (r_slot_state[i] == ttrrs_pkg::ST_BLOCKED)))
                                n_slot_state[i] = ttrrs_pkg::ST_READY;
                        end
                        n_slot_state[r_cur] = ttrrs_pkg::ST_FINISHED;
                    end
                end
                ttrrs_pkg::CMD_BLOCK: begin
                    if (!cur_live) sts = ttrrs_pkg::STS_INVALID;
                    else n_slot_state[r_cur] = ttrrs_pkg::ST_BLOCKED;
                end
                ttrrs_pkg::CMD_WAKEUP: begin
                    tid = r_tgt;
                    if (tst == ttrrs_pkg::ST_READY || tst == ttrrs_pkg::ST_BLOCKED)
                        n_slot_state[r_tgt[SW-1:0]] = ttrrs_pkg::ST_READY;
                    else
                        sts = ttrrs_pkg::STS_INVALID;
                end
                ttrrs_pkg::CMD_JOIN: begin
                    tid = r_tgt;
                    if (tst == ttrrs_pkg::ST_FREE) begin
                        sts = ttrrs_pkg::STS_INVALID;
                    end else if (tst == ttrrs_pkg::ST_FINISHED) begin
                        jv  = rv_rdata;
                        dec = (w_count != '0) ? w_count - 1'b1 : '0;
                        if (dec == '0) begin
                            n_slot_state[r_tgt[SW-1:0]] = ttrrs_pkg::ST_FREE;
                            n_wvalid[r_tgt[SW-1:0]]     = 1'b0;
                        end else begin
                            w_we    = 1'b1;
                            w_wdata = {dec, w_mask & ~(N'(1) << r_cur)};
                            n_wvalid[r_tgt[SW-1:0]] = 1'b1;
                        end
                    end else begin
                        sts = ttrrs_pkg::STS_BLOCKED;
                        if (!w_mask[r_cur]) begin
                            w_we    = 1'b1;
                            w_wdata = {w_count + 1'b1, w_mask | (N'(1) << r_cur)};
                            n_wvalid[r_tgt[SW-1:0]] = 1'b1;
                        end
                        n_slot_state[r_cur] = ttrrs_pkg::ST_BLOCKED;
                    end
                end
                ttrrs_pkg::CMD_SCHEDULE: begin
                    for (int i = N - 1; i >= 0; i--) begin
                        if (rdy[i]) begin
                            found = 1'b1;
                            pick  = SW'(i);
                        end
                    end
                    for (int i = N - 1; i >= 0; i--) begin
                        if (rdy[i] && hi[i]) pick = SW'(i);
                    end
                    if (found) begin
                        n_cur  = pick;
                        n_scan = pick + 1'b1;
                        tid    = 4'(pick);
                    end else begin
                        sts = (r_live == '0) ? ttrrs_pkg::STS_ALL_DONE : ttrrs_pkg::STS_NONE_RDY;
                    end
                end
                default: begin
                end
            endcase
        end
        n_odata = {4'd0, r_live, jv, tid, sts};
        n_odata[75:71] = n_live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ttrrs_pkg::PH_IDLE;
            r_ovalid <= 1'b0;
            r_wvalid <= '0;
            r_cur    <= '0;
            r_scan   <= '0;
            r_live   <= ttrrs_pkg::LIVE_W'(1);
            for (int i = 0; i < N; i++)
                r_slot_state[i] <= (i == 0) ? ttrrs_pkg::ST_READY : ttrrs_pkg::ST_FREE;
        end else begin
            r_phase  <= n_phase;
            r_wvalid <= n_wvalid;
            r_cur    <= n_cur;
            r_scan   <= n_scan;
            r_live   <= n_live;
            for (int i = 0; i < N; i++) r_slot_state[i] <= n_slot_state[i];
            if (load_out) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= ttrrs_pkg::t_cmd'(s_axis_tdata[2:0]);
            r_tgt <= s_axis_tdata[6:3];
            r_val <= s_axis_tdata[70:7];
        end
        if (load_out) r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef NO_ASSERTIONS
    a_exec_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ttrrs_pkg::PH_EXEC |=> m_axis_tvalid)
        else $error("result not presented after execute");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ttrrs_pkg::PH_EXEC |-> !s_axis_tready)
        else $error("word accepted while a command is in flight");
    a_reserved_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_state[ttrrs_pkg::RESERVED_SLOT] == ttrrs_pkg::ST_FREE)
        else $error("reserved slot left free state");
`endif

endmodule

// ===== sim/ttrrs_checker.sv =====
// ----------------------------------------------------------------------------
// ttrrs_checker
// watches both stream channels of the thread scheduler, keeps its own copy of
// the thread table, predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
module ttrrs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [79:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SLOTS   = ttrrs_pkg::SLOTS;
    localparam int SLOT_W  = ttrrs_pkg::SLOT_W;
    localparam int VALUE_W = ttrrs_pkg::VALUE_W;
    localparam int LIVE_W  = ttrrs_pkg::LIVE_W;

    typedef struct packed {
        logic [LIVE_W-1:0]  live;
        logic [VALUE_W-1:0] jval;
        logic [SLOT_W-1:0]  tid;
        logic [2:0]         status;
    } t_answer;

    ttrrs_pkg::t_slot_st tbl_state [SLOTS];
    logic [VALUE_W-1:0]  tbl_retval [SLOTS];
    logic [SLOTS-1:0]    tbl_waiters [SLOTS];
    int                  tbl_wcount [SLOTS];
    int                  cur_slot;
    int                  scan_ptr;
    int                  live_cnt;
    t_answer             answer_q [$];
    int                  fails;

    assign o_fail_count = fails;
    assign o_pending    = answer_q.size();

    function automatic bit slot_live(int s);
        return tbl_state[s] == ttrrs_pkg::ST_READY || tbl_state[s] == ttrrs_pkg::ST_BLOCKED;
    endfunction

    function automatic t_answer mk(ttrrs_pkg::t_status st, int id, logic [VALUE_W-1:0] jv);
        t_answer a;
        a.status = st;
        a.tid    = SLOT_W'(id);
        a.jval   = jv;
        a.live   = LIVE_W'(live_cnt);
        return a;
    endfunction

    function automatic t_answer run_command(ttrrs_pkg::t_cmd cmd, int tgt,
                                            logic [VALUE_W-1:0] xv);
        int i;
        logic [VALUE_W-1:0] v;
        case (cmd)
            ttrrs_pkg::CMD_CREATE: begin
                for (i = 1; i < SLOTS - 1; i++) begin
                    if (tbl_state[i] == ttrrs_pkg::ST_FREE) begin
                        tbl_state[i]   = ttrrs_pkg::ST_READY;
                        tbl_retval[i]  = '0;
                        tbl_waiters[i] = '0;
                        tbl_wcount[i]  = 0;
                        if (live_cnt < 31) live_cnt++;
                        return mk(ttrrs_pkg::STS_OK, i, '0);
                    end
                end
                return mk(ttrrs_pkg::STS_NO_FREE, 0, '0);
            end
            ttrrs_pkg::CMD_EXIT: begin
                if (!slot_live(cur_slot)) return mk(ttrrs_pkg::STS_INVALID, cur_slot, '0);
                tbl_state[cur_slot]  = ttrrs_pkg::ST_FINISHED;
                tbl_retval[cur_slot] = xv;
                if (live_cnt > 0) live_cnt--;
                for (i = 0; i < SLOTS; i++)
                    if (tbl_waiters[cur_slot][i] && slot_live(i))
                        tbl_state[i] = ttrrs_pkg::ST_READY;
                return mk(ttrrs_pkg::STS_OK, cur_slot, '0);
            end
            ttrrs_pkg::CMD_BLOCK: begin
                if (!slot_live(cur_slot)) return mk(ttrrs_pkg::STS_INVALID, cur_slot, '0);
                tbl_state[cur_slot] = ttrrs_pkg::ST_BLOCKED;
                return mk(ttrrs_pkg::STS_OK, cur_slot, '0);
            end
            ttrrs_pkg::CMD_WAKEUP: begin
                if (!slot_live(tgt)) return mk(ttrrs_pkg::STS_INVALID, tgt, '0);
                tbl_state[tgt] = ttrrs_pkg::ST_READY;
                return mk(ttrrs_pkg::STS_OK, tgt, '0);
            end
            ttrrs_pkg::CMD_JOIN: begin
                if (tbl_state[tgt] == ttrrs_pkg::ST_FREE)
                    return mk(ttrrs_pkg::STS_INVALID, tgt, '0);
                if (tbl_state[tgt] == ttrrs_pkg::ST_FINISHED) begin
                    v = tbl_retval[tgt];
                    if (tbl_wcount[tgt] > 0) tbl_wcount[tgt]--;
                    tbl_waiters[tgt][cur_slot] = 1'b0;
                    if (tbl_wcount[tgt] == 0) begin
                        tbl_state[tgt]   = ttrrs_pkg::ST_FREE;
                        tbl_waiters[tgt] = '0;
                    end
                    return mk(ttrrs_pkg::STS_OK, tgt, v);
                end
                if (!tbl_waiters[tgt][cur_slot]) begin
                    tbl_waiters[tgt][cur_slot] = 1'b1;
                    tbl_wcount[tgt]++;
                end
                tbl_state[cur_slot] = ttrrs_pkg::ST_BLOCKED;
                return mk(ttrrs_pkg::STS_BLOCKED, tgt, '0);
            end
            ttrrs_pkg::CMD_SCHEDULE: begin
                i = scan_ptr;
                repeat (SLOTS) begin
                    if (i != SLOTS - 1 && tbl_state[i] == ttrrs_pkg::ST_READY) begin
                        cur_slot = i;
                        scan_ptr = (i + 1) % SLOTS;
                        return mk(ttrrs_pkg::STS_OK, i, '0);
                    end
                    i = (i + 1) % SLOTS;
                end
                return mk(live_cnt == 0 ? ttrrs_pkg::STS_ALL_DONE : ttrrs_pkg::STS_NONE_RDY,
                          cur_slot, '0);
            end
            default: return mk(ttrrs_pkg::STS_OK, cur_slot, '0);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_answer exp_a;
        t_answer got;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                tbl_state[s]   = ttrrs_pkg::ST_FREE;
                tbl_retval[s]  = '0;
                tbl_waiters[s] = '0;
                tbl_wcount[s]  = 0;
            end
            tbl_state[0] = ttrrs_pkg::ST_READY;
            cur_slot = 0;
            scan_ptr = 0;
            live_cnt = 1;
            answer_q.delete();
            fails = 0;
        end else begin
            // result word checked before the new command so ordering is fixed
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[75:0];
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fails++;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (got.status !== exp_a.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_a.status, got.status);
                        fails++;
                    end
                    if (got.tid !== exp_a.tid) begin
                        $display("%0t: thread_id exp %0d got %0d", $time, exp_a.tid, got.tid);
                        fails++;
                    end
                    if (got.jval !== exp_a.jval) begin
                        $display("%0t: join_value exp %h got %h", $time, exp_a.jval, got.jval);
                        fails++;
                    end
                    if (got.live !== exp_a.live) begin
                        $display("%0t: live_threads exp %0d got %0d", $time, exp_a.live,
                                 got.live);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                answer_q.push_back(run_command(ttrrs_pkg::t_cmd'(i_in_data[2:0]),
                                               int'(i_in_data[6:3]), i_in_data[70:7]));
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives directed and random thread commands into the scheduler with random
// gaps and back-pressure; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // command, target_id, exit_value, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // status, thread_id, join_value, live_threads, pad
    int          fail_count;
    int          pending;
    int          cycles;
    bit          long_stall;

    thread_table_round_robin_scheduler dut (.*);

    ttrrs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one word offered at the falling edge, held until accepted;
    // valid only drops when a gap follows
    task automatic send_word(ttrrs_pkg::t_cmd cmd, logic [3:0] tgt, logic [63:0] xv);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata  <= {1'b0, xv, tgt, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge i_clk);
                long_stall = 1'b0;
            end
            if ($urandom_range(0, 99) < 3) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(5, 25)) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        ttrrs_pkg::t_cmd c;
        int   k;
        cycles        = 0;
        long_stall    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: fill the table, overflow create, block/wake/join/exit paths
        for (k = 0; k < 15; k++) send_word(ttrrs_pkg::CMD_CREATE, 4'd0, '0);
        send_word(ttrrs_pkg::CMD_JOIN, 4'd15, '0);
        send_word(ttrrs_pkg::CMD_WAKEUP, 4'd15, '0);
        send_word(ttrrs_pkg::CMD_JOIN, 4'd3, '0);
        send_word(ttrrs_pkg::CMD_JOIN, 4'd3, '0);
        send_word(ttrrs_pkg::CMD_SCHEDULE, 4'd0, '0);
        send_word(ttrrs_pkg::CMD_EXIT, 4'd0, '1);
        send_word(ttrrs_pkg::CMD_WAKEUP, 4'd1, '0);
        send_word(ttrrs_pkg::CMD_RSVD6, 4'd0, '0);
        send_word(ttrrs_pkg::CMD_RSVD7, 4'hf, '1);
        send_word(ttrrs_pkg::CMD_BLOCK, 4'd0, '0);
        long_stall = 1'b1;
        // random: mostly real commands with targets biased to low slots
        for (k = 0; k < 1050; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2:    c = ttrrs_pkg::CMD_CREATE;
                3, 4:       c = ttrrs_pkg::CMD_EXIT;
                5:          c = ttrrs_pkg::CMD_BLOCK;
                6, 7:       c = ttrrs_pkg::CMD_WAKEUP;
                8, 9, 10:   c = ttrrs_pkg::CMD_JOIN;
                11:         c = ttrrs_pkg::t_cmd'($urandom_range(6, 7));
                default:    c = ttrrs_pkg::CMD_SCHEDULE;
            endcase
            send_word(c, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5)),
                      rand_value());
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
